// ===== rtl/fasa_pkg.sv =====
// ----------------------------------------------------------------------------
// fasa_pkg
// Constants and the NaN test used by the non-negative single-precision adder
// and the absolute-value sum accumulator.
// ----------------------------------------------------------------------------
package fasa_pkg;

  localparam logic [31:0] ABS_MASK  = 32'h7FFF_FFFF;
  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

  // Detect a NaN encoding
  function automatic logic is_nan(input logic [31:0] v);
    is_nan = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

endpackage

// ===== rtl/float_abs_sum_accumulator.sv =====
// ----------------------------------------------------------------------------
// float_abs_sum_accumulator
// Sum of absolute values of a stream of single-precision numbers.
// ----------------------------------------------------------------------------
// Accepts one element per cycle. Each element's absolute value is added to a
// running sum (the adder closes the accumulation loop on the sum register); an
// element marked last delivers the finished sum in the following cycle through
// an output register and restarts the sum at +0. NaN gives 0x7FC00000. The
// input stalls only while an undelivered result waits.
module float_abs_sum_accumulator
  import fasa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [31:0] value_bits,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] sum_bits
);

  logic [31:0] running_sum;
  logic [31:0] add_y;
  logic        in_xfer;

  fasa_add u_add (
    .a(running_sum),
    .b(value_bits & ABS_MASK),
    .y(add_y)
  );

  assign ready   = !out_valid || out_ready;
  assign in_xfer = valid && ready;

  // Advance the running sum; clear it at the end of a vector
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (in_xfer) begin
      running_sum <= last ? 32'd0 : add_y;
    end
  end

  // Hold the result until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && last) begin
      sum_bits <= add_y;
    end
  end

  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_xfer && last |=> running_sum == 32'd0) else $error("sum not cleared");
  a_res: assert property (@(posedge clk) disable iff (rst)
    in_xfer && last |=> out_valid) else $error("result lost");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !ready) else $error("overrun");

endmodule

// ===== rtl/fasa_add.sv =====
// ----------------------------------------------------------------------------
// fasa_add
// Combinational adder for two non-negative single-precision values with
// round-to-nearest-even and subnormal support.
// ----------------------------------------------------------------------------
module fasa_add
  import fasa_pkg::*;
(
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic [31:0] big, sml;
  logic [8:0]  ea;
  logic [7:0]  eb, d;
  logic [26:0] ma, mb, mbs;
  logic [26:0] lost_mask;
  logic [27:0] sum;
  logic [26:0] sn;
  logic [2:0]  grs;
  logic [24:0] m;
  logic        rnd;

  always_comb begin
    // Order operands by magnitude
    if (a < b) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    ea = (big[30:23] == 8'd0) ? 9'd1 : {1'b0, big[30:23]};
    eb = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    ma = {(big[30:23] != 8'd0), big[22:0], 3'b000};
    mb = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
    d  = ea[7:0] - eb;
    // Align with sticky
    lost_mask = '0;
    if (d > 8'd26) begin
      mbs = {26'd0, (mb != 27'd0)};
    end else begin
      lost_mask = ~(27'h7FF_FFFF << d[4:0]);
      mbs = (mb >> d[4:0]) | {26'd0, ((mb & lost_mask) != 27'd0)};
    end
    sum = {1'b0, ma} + {1'b0, mbs};
    if (sum[27]) begin
      sn = sum[27:1] | {26'd0, sum[0]};
      ea = ea + 9'd1;
    end else begin
      sn = sum[26:0];
    end
    // Round to nearest even
    grs = sn[2:0];
    rnd = (grs > 3'd4) || ((grs == 3'd4) && sn[3]);
    m   = {1'b0, sn[26:3]} + {24'd0, rnd};
    if (m[24]) begin
      m  = m >> 1;
      ea = ea + 9'd1;
    end
    // Pack result and handle special cases
    if (is_nan(a) || is_nan(b)) begin
      y = QNAN_BITS;
    end else if (a == INF_BITS || b == INF_BITS) begin
      y = INF_BITS;
    end else if (ea >= 9'd255) begin
      y = INF_BITS;
    end else if (m[23]) begin
      y = {1'b0, ea[7:0], m[22:0]};
    end else begin
      y = {8'd0, m[23:0]};
    end
  end

endmodule
